// File: src/hlcfp_pkg.sv
// ----------------------------------------------------------------------------
// hlcfp_pkg
// Shared types and constants of the sync/length/checksum frame parser.
// ----------------------------------------------------------------------------
package hlcfp_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CSUM_BAD = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_HDR_BAD  = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_SYNC_FIRST  = 1'b0,
    REG_SYNC_SECOND = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;

  // frame job queue between parser and drain
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    status_t     status;
    logic [7:0]  func;
    logic [6:0]  len;
    logic        bank;
    logic        has_payload;
    logic [31:0] good;
    logic [31:0] bad;
    logic [31:0] oversize;
  } job_t;

  typedef struct packed {
    logic       we;
    logic       bank;
    logic [5:0] idx;
    logic [7:0] data;
  } store_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

// File: src/hlcfp_if.sv
// ----------------------------------------------------------------------------
// hlcfp_if
// Valid/ready channels of the frame parser: received bytes and results.
// ----------------------------------------------------------------------------
interface hlcfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hlcfp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  func_code;
  logic [6:0]  frame_len;
  logic [5:0]  byte_index;
  logic [7:0]  payload_byte;
  logic        last;
  logic [31:0] good_total;
  logic [31:0] bad_total;
  logic [31:0] oversize_total;

  modport source (output valid, output status, output func_code, output frame_len,
                  output byte_index, output payload_byte, output last,
                  output good_total, output bad_total, output oversize_total,
                  input ready);
  modport sink (input valid, input status, input func_code, input frame_len,
                input byte_index, input payload_byte, input last,
                input good_total, input bad_total, input oversize_total,
                output ready);
endinterface

// File: src/header_length_checksum_frame_parser.sv
// ----------------------------------------------------------------------------
// header_length_checksum_frame_parser
// Two-sync-byte frame parser with length check, 8-bit sum and payload store.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle. The parser hunts for the two sync
// bytes, reads function code and length, captures the payload into one of two
// store banks and checks the additive checksum. A good frame of N > 0 payload
// bytes yields N results, one per cycle unless the output stalls, read from
// the store's single read port; every other finished frame yields one status
// result. Frames reach the drain through a four-entry job queue; input stalls
// while that queue is full, and in the payload phase while both store banks
// still hold undelivered frames. The user writes sync values through the cfg
// port only while the block is idle; the block itself does not enforce this.
module header_length_checksum_frame_parser
  import hlcfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_idx,
  input  logic [7:0]            cfg_data,
  hlcfp_byte_if.sink            in_chan,
  hlcfp_result_if.source        out_chan
);

  job_t      push_job, head_job;
  logic      job_push, job_full, q_pop, q_empty;
  store_wr_t store_wr;
  bank_rel_t bank_rel;

  hlcfp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_reg_t'(cfg_idx)),
    .cfg_data (cfg_data),
    .in_valid (in_chan.valid),
    .in_byte  (in_chan.rx_byte),
    .in_ready (in_chan.ready),
    .job_push (job_push),
    .job      (push_job),
    .job_full (job_full),
    .store_wr (store_wr),
    .bank_rel (bank_rel)
  );

  hlcfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .full     (job_full),
    .pop      (q_pop),
    .head     (head_job),
    .empty    (q_empty)
  );

  hlcfp_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .store_wr           (store_wr),
    .q_empty            (q_empty),
    .q_head             (head_job),
    .q_pop              (q_pop),
    .bank_rel           (bank_rel),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_status         (out_chan.status),
    .out_func_code      (out_chan.func_code),
    .out_frame_len      (out_chan.frame_len),
    .out_byte_index     (out_chan.byte_index),
    .out_payload_byte   (out_chan.payload_byte),
    .out_last           (out_chan.last),
    .out_good_total     (out_chan.good_total),
    .out_bad_total      (out_chan.bad_total),
    .out_oversize_total (out_chan.oversize_total)
  );

endmodule

// File: src/hlcfp_front.sv
// ----------------------------------------------------------------------------
// hlcfp_front
// Byte parser: sync hunt, header, payload capture, checksum check, counters.
// Pushes one job per finished frame into the job queue.
// ----------------------------------------------------------------------------
module hlcfp_front
  import hlcfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  cfg_reg_t   cfg_idx,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  output logic       job_push,
  output job_t       job,
  input  logic       job_full,
  output store_wr_t  store_wr,
  input  bank_rel_t  bank_rel
);

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_SYNC2 = 6'b000010,
    PH_FUNC  = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_SUM   = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [6:0]  fill_r, fill_nxt;
  logic        wbank_r, wbank_nxt;
  logic [1:0]  busy_r, busy_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;
  logic [31:0] over_r, over_nxt;
  logic [7:0]  sync1_r, sync2_r;
  logic        accept;
  logic        frame_end;

  // stall payload capture while the write bank still holds an undelivered frame
  assign in_ready = !job_full && !((phase_r == PH_DATA) && busy_r[wbank_r]);
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    func_nxt  = func_r;
    len_nxt   = len_r;
    fill_nxt  = fill_r;
    wbank_nxt = wbank_r;
    busy_nxt  = busy_r;
    good_nxt  = good_r;
    bad_nxt   = bad_r;
    over_nxt  = over_r;
    frame_end = 1'b0;
    job_push  = 1'b0;
    job       = '0;
    store_wr  = '0;

    if (bank_rel.valid) begin
      busy_nxt[bank_rel.bank] = 1'b0;
    end

    if (accept) begin
      case (phase_r)
        PH_IDLE: begin
          if (in_byte == sync1_r) begin
            sum_nxt   = in_byte;
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (in_byte == sync2_r) begin
            sum_nxt   = sum_r + in_byte;
            phase_nxt = PH_FUNC;
          end else if (in_byte == sync1_r) begin
            sum_nxt = in_byte;
          end else begin
            bad_nxt    = bad_r + 32'd1;
            job_push   = 1'b1;
            job.status = ST_HDR_BAD;
            frame_end  = 1'b1;
          end
        end
        PH_FUNC: begin
          func_nxt  = in_byte;
          sum_nxt   = sum_r + in_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (in_byte > 8'(MAX_PAYLOAD)) begin
            over_nxt   = over_r + 32'd1;
            bad_nxt    = bad_r + 32'd1;
            job_push   = 1'b1;
            job.status = ST_TOO_BIG;
            job.func   = func_r;
            frame_end  = 1'b1;
          end else begin
            len_nxt   = in_byte[6:0];
            sum_nxt   = sum_r + in_byte;
            fill_nxt  = 7'd0;
            phase_nxt = (in_byte == 8'd0) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          store_wr.we   = 1'b1;
          store_wr.bank = wbank_r;
          store_wr.idx  = fill_r[5:0];
          store_wr.data = in_byte;
          fill_nxt      = fill_r + 7'd1;
          sum_nxt       = sum_r + in_byte;
          if (fill_r + 7'd1 >= len_r) begin
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          job_push  = 1'b1;
          job.func  = func_r;
          job.len   = len_r;
          frame_end = 1'b1;
          if (in_byte == sum_r) begin
            good_nxt        = good_r + 32'd1;
            job.status      = ST_GOOD;
            job.bank        = wbank_r;
            job.has_payload = (len_r != 7'd0);
            if (len_r != 7'd0) begin
              // hand the bank to the drain side and capture into the other one
              busy_nxt[wbank_r] = 1'b1;
              wbank_nxt         = !wbank_r;
            end
          end else begin
            bad_nxt    = bad_r + 32'd1;
            job.status = ST_CSUM_BAD;
          end
        end
        default: begin
          frame_end = 1'b1;
        end
      endcase
    end

    if (frame_end) begin
      phase_nxt = PH_IDLE;
      sum_nxt   = 8'd0;
      func_nxt  = 8'd0;
      len_nxt   = 7'd0;
      fill_nxt  = 7'd0;
    end

    job.good     = good_nxt;
    job.bad      = bad_nxt;
    job.oversize = over_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sum_r   <= 8'd0;
      func_r  <= 8'd0;
      len_r   <= 7'd0;
      fill_r  <= 7'd0;
      wbank_r <= 1'b0;
      busy_r  <= 2'b00;
      good_r  <= 32'd0;
      bad_r   <= 32'd0;
      over_r  <= 32'd0;
      sync1_r <= SYNC_FIRST_RST;
      sync2_r <= SYNC_SECOND_RST;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      func_r  <= func_nxt;
      len_r   <= len_nxt;
      fill_r  <= fill_nxt;
      wbank_r <= wbank_nxt;
      busy_r  <= busy_nxt;
      good_r  <= good_nxt;
      bad_r   <= bad_nxt;
      over_r  <= over_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_SYNC_FIRST:  sync1_r <= cfg_data;
          REG_SYNC_SECOND: sync2_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: src/hlcfp_queue.sv
// ----------------------------------------------------------------------------
// hlcfp_queue
// Short job FIFO between the parser and the result drain.
// ----------------------------------------------------------------------------
module hlcfp_queue
  import hlcfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full  = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: src/hlcfp_back.sv
// ----------------------------------------------------------------------------
// hlcfp_back
// Result drain: owns the two-bank payload store, walks each job and emits
// its results through a read stage and an output register.
// ----------------------------------------------------------------------------
module hlcfp_back
  import hlcfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  store_wr_t   store_wr,
  input  logic        q_empty,
  input  job_t        q_head,
  output logic        q_pop,
  output bank_rel_t   bank_rel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_func_code,
  output logic [6:0]  out_frame_len,
  output logic [5:0]  out_byte_index,
  output logic [7:0]  out_payload_byte,
  output logic        out_last,
  output logic [31:0] out_good_total,
  output logic [31:0] out_bad_total,
  output logic [31:0] out_oversize_total
);

  localparam int AW         = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int STORE_ROWS = 2 * (1 << AW);

  logic [7:0]    store_mem [STORE_ROWS];

  // walk stage
  logic          active_r;
  job_t          job_r;
  logic [AW-1:0] idx_r;
  // read stage
  logic          b_valid_r;
  job_t          b_job_r;
  logic [AW-1:0] b_idx_r;
  logic          b_last_r;
  logic [7:0]    rd_data_r;
  // output stage
  logic          out_valid_r;
  job_t          o_job_r;
  logic [AW-1:0] o_idx_r;
  logic          o_last_r;
  logic [7:0]    o_data_r;

  logic c_free, b_move, b_free, issue, a_last, finish;

  assign c_free = !out_valid_r || out_ready;
  assign b_move = b_valid_r && c_free;
  assign b_free = !b_valid_r || b_move;
  assign issue  = active_r && b_free;
  assign a_last = !job_r.has_payload || ((7'(idx_r) + 7'd1) == job_r.len);
  assign finish = issue && a_last;
  assign q_pop  = !q_empty && (!active_r || finish);

  // free the bank once its final byte has been read
  assign bank_rel.valid = finish && job_r.has_payload;
  assign bank_rel.bank  = job_r.bank;

  always_ff @(posedge clk) begin
    if (store_wr.we) begin
      store_mem[{store_wr.bank, store_wr.idx[AW-1:0]}] <= store_wr.data;
    end
    if (issue) begin
      rd_data_r <= store_mem[{job_r.bank, idx_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= 1'b1;
      end else if (finish) begin
        active_r <= 1'b0;
      end
      if (b_free) begin
        b_valid_r <= issue;
      end
      if (c_free) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
      idx_r <= '0;
    end else if (issue) begin
      idx_r <= idx_r + 1'b1;
    end
    if (issue) begin
      b_job_r  <= job_r;
      b_idx_r  <= idx_r;
      b_last_r <= a_last;
    end
    if (b_move) begin
      o_job_r  <= b_job_r;
      o_idx_r  <= b_idx_r;
      o_last_r <= b_last_r;
      o_data_r <= b_job_r.has_payload ? rd_data_r : 8'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_job_r.status;
  assign out_func_code      = o_job_r.func;
  assign out_frame_len      = o_job_r.len;
  assign out_byte_index     = 6'(o_idx_r);
  assign out_payload_byte   = o_data_r;
  assign out_last           = o_last_r;
  assign out_good_total     = o_job_r.good;
  assign out_bad_total      = o_job_r.bad;
  assign out_oversize_total = o_job_r.oversize;

endmodule

// File: src/hlcfp_checker.sv
// ----------------------------------------------------------------------------
// hlcfp_checker
// Port-level checks on the result stream of the frame parser.
// ----------------------------------------------------------------------------
module hlcfp_checker
  import hlcfp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [6:0] frame_len,
  input logic [5:0] byte_index,
  input logic [7:0] payload_byte,
  input logic       last
);

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // only a good frame with payload spreads over several results
  a_multi_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> status == ST_GOOD && frame_len != 7'd0)
    else $error("non-final result outside a good payload frame");

  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_GOOD |-> last && payload_byte == 8'd0 && byte_index == 6'd0)
    else $error("failure result is not a single empty result");

  // final byte of a payload frame sits at frame_len - 1
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last && status == ST_GOOD && frame_len != 7'd0
      |-> byte_index == 6'(frame_len - 7'd1))
    else $error("final payload result at wrong index");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(byte_index) && $stable(payload_byte))
    else $error("stalled result changed");

endmodule

bind header_length_checksum_frame_parser hlcfp_checker u_hlcfp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .status       (out_chan.status),
  .frame_len    (out_chan.frame_len),
  .byte_index   (out_chan.byte_index),
  .payload_byte (out_chan.payload_byte),
  .last         (out_chan.last)
);
